// ----- rtl/core/lzwd_pkg.sv -----
// Shared constants and types of the LZSS window decoder.
package lzwd_pkg;

  localparam int unsigned WIN_AW     = 12;
  localparam int unsigned FILL_W     = WIN_AW + 1;
  localparam int unsigned CNT_W      = 5;

  localparam logic [FILL_W-1:0] WIN_DEPTH    = FILL_W'(4096);
  localparam logic [WIN_AW-1:0] WR_START     = WIN_AW'(4096 - 18);
  localparam logic [7:0]        SPACE_BYTE   = 8'h20;
  localparam logic [CNT_W-1:0]  MIN_MATCH_M1 = CNT_W'(2);
  localparam logic [15:0]       FLAG_FILL    = 16'hff00;

  // One decoded byte handed from the engine to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // Window memory access: one read request and one write request.
  typedef struct packed {
    logic              re;
    logic [WIN_AW-1:0] raddr;
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

// ----- rtl/core/lzwd_if.sv -----
// Valid/ready channels for compressed input bytes and decoded output bytes.
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source(output valid, output in_byte, output stream_end, input ready);
  modport sink(input valid, input in_byte, input stream_end, output ready);
endinterface

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, output out_byte, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- rtl/core/lzwd_window_ram.sv -----
// 4096 x 8 window memory with one write port and one registered read port.
module lzwd_window_ram (
  input  logic                     clk,
  input  lzwd_pkg::ram_req_t       req,
  output logic [7:0]               rdata
);

  logic [7:0] mem [0:(1 << lzwd_pkg::WIN_AW)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- rtl/core/lzwd_engine.sv -----
// Flag parsing, copy sequencing and window bookkeeping of the LZSS decoder.
module lzwd_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           in_byte,
  input  logic                 in_end,
  input  logic                 out_free,
  output logic                 idle,
  output lzwd_pkg::emit_t      emit,
  output lzwd_pkg::ram_req_t   ram_req,
  input  logic [7:0]           ram_q
);

  localparam int unsigned AW = lzwd_pkg::WIN_AW;
  localparam int unsigned FW = lzwd_pkg::FILL_W;
  localparam int unsigned CW = lzwd_pkg::CNT_W;

  logic [15:0]   flag_r, flag_nxt;
  logic          pair_pend_r, pair_pend_nxt;
  logic [7:0]    pair_lo_r, pair_lo_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [CW-1:0] iss_left_r, iss_left_nxt;
  logic [CW-1:0] cons_left_r, cons_left_nxt;
  logic          end_pend_r, end_pend_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_valid_r, rd_valid_nxt;
  logic          fwd_hit_r, fwd_hit_nxt;
  logic [7:0]    fwd_data_r, fwd_data_nxt;

  logic          consume;
  logic          lit;
  logic          issue;
  logic          last_copy;
  logic [AW-1:0] rd_off;
  logic          rd_written;
  logic [7:0]    rd_data;
  logic [CW-1:0] copy_cnt;

  assign idle      = (cons_left_r == '0);
  assign consume   = rd_pend_r && out_free;
  assign last_copy = (cons_left_r == CW'(1));
  assign lit       = acc && !pair_pend_r && flag_r[8] && flag_r[0];
  assign issue     = (iss_left_r != '0) && (!rd_pend_r || consume);
  assign copy_cnt  = {1'b0, in_byte[3:0]} + lzwd_pkg::MIN_MATCH_M1 + CW'(1);

  // An entry has been written in this stream when its offset from the start
  // position lies below the number of bytes written so far.
  assign rd_off     = src_r - lzwd_pkg::WR_START;
  assign rd_written = ({1'b0, rd_off} < fill_r);

  assign rd_data = fwd_hit_r  ? fwd_data_r :
                   rd_valid_r ? ram_q      : lzwd_pkg::SPACE_BYTE;

  always_comb begin
    emit.valid = lit || consume;
    emit.data  = lit ? in_byte : rd_data;
    emit.last  = lit || last_copy;

    ram_req.re    = issue;
    ram_req.raddr = src_r;
    ram_req.we    = emit.valid;
    ram_req.waddr = wp_r;
    ram_req.wdata = emit.data;
  end

  always_comb begin
    flag_nxt      = flag_r;
    pair_pend_nxt = pair_pend_r;
    pair_lo_nxt   = pair_lo_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    src_nxt       = src_r;
    iss_left_nxt  = iss_left_r;
    cons_left_nxt = cons_left_r;
    end_pend_nxt  = end_pend_r;
    rd_pend_nxt   = rd_pend_r;
    rd_valid_nxt  = rd_valid_r;
    fwd_hit_nxt   = fwd_hit_r;
    fwd_data_nxt  = fwd_data_r;

    // A read issued in the same cycle as a write to its address sees the old
    // entry, so the written byte is kept aside and used instead.
    if (issue) begin
      src_nxt      = src_r + AW'(1);
      iss_left_nxt = iss_left_r - CW'(1);
      rd_pend_nxt  = 1'b1;
      rd_valid_nxt = rd_written;
      fwd_hit_nxt  = ram_req.we && (ram_req.waddr == src_r);
      fwd_data_nxt = ram_req.wdata;
    end else if (consume) begin
      rd_pend_nxt = 1'b0;
    end

    if (emit.valid) begin
      wp_nxt = wp_r + AW'(1);
      if (fill_r != lzwd_pkg::WIN_DEPTH) begin
        fill_nxt = fill_r + FW'(1);
      end
    end

    if (consume) begin
      cons_left_nxt = cons_left_r - CW'(1);
    end

    if (acc) begin
      if (pair_pend_r) begin
        src_nxt       = {in_byte[7:4], pair_lo_r};
        iss_left_nxt  = copy_cnt;
        cons_left_nxt = copy_cnt;
        pair_pend_nxt = 1'b0;
        flag_nxt      = flag_r >> 1;
        end_pend_nxt  = in_end;
      end else if (!flag_r[8]) begin
        flag_nxt = lzwd_pkg::FLAG_FILL | {8'h00, in_byte};
      end else if (flag_r[0]) begin
        flag_nxt = flag_r >> 1;
      end else begin
        pair_lo_nxt   = in_byte;
        pair_pend_nxt = 1'b1;
      end
    end

    // Stream end restores the start state once the item's last byte is out.
    if ((acc && in_end && !pair_pend_r) || (consume && last_copy && end_pend_r)) begin
      flag_nxt      = '0;
      pair_pend_nxt = 1'b0;
      wp_nxt        = lzwd_pkg::WR_START;
      fill_nxt      = '0;
      end_pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= '0;
      pair_pend_r <= 1'b0;
      wp_r        <= lzwd_pkg::WR_START;
      fill_r      <= '0;
      iss_left_r  <= '0;
      cons_left_r <= '0;
      end_pend_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      pair_pend_r <= pair_pend_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      iss_left_r  <= iss_left_nxt;
      cons_left_r <= cons_left_nxt;
      end_pend_r  <= end_pend_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_lo_r  <= pair_lo_nxt;
    src_r      <= src_nxt;
    rd_valid_r <= rd_valid_nxt;
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  a_rd_within_copy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (cons_left_r != '0))
    else $error("read outstanding with no copy byte left");

  a_issue_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    iss_left_r <= cons_left_r)
    else $error("more reads left than bytes to deliver");

  a_accept_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (cons_left_r == '0))
    else $error("input taken during a copy");

  a_last_all_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && last_copy) |-> (iss_left_r == '0))
    else $error("copy finished with reads still to issue");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lzwd_pkg::WIN_DEPTH)
    else $error("fill count beyond window depth");

endmodule

// ----- rtl/core/lzss_window_decoder_top.sv -----
// Top level of the LZSS window decoder: handshakes, output register and window.
// A literal appears on the output in the cycle after it is accepted. A copy's bytes are
// read from the window and pass through the output register, one byte a cycle unless
// the output stalls. Flag, literal and first pair bytes are taken one a cycle unless the
// output stalls; a pair's second byte holds off input until its length+3 bytes are out.
// Reset is synchronous; the window is not swept: a fill count marks entries written in
// the current stream, all others read as space, and stream end restores reset state.
module lzss_window_decoder_top (
  input  logic             clk,
  input  logic             rst_n,
  lzwd_in_if.sink          in_ch,
  lzwd_out_if.source       out_ch
);

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_free;
  logic                 eng_idle;
  logic                 acc;
  lzwd_pkg::emit_t      emit;
  lzwd_pkg::ram_req_t   ram_req;
  logic [7:0]           ram_q;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = eng_idle && out_free;
  assign acc          = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit.valid;
      out_byte_nxt  = emit.data;
      out_last_nxt  = emit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  lzwd_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_byte  (in_ch.in_byte),
    .in_end   (in_ch.stream_end),
    .out_free (out_free),
    .idle     (eng_idle),
    .emit     (emit),
    .ram_req  (ram_req),
    .ram_q    (ram_q)
  );

  lzwd_window_ram u_window (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_q)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the LZSS window decoder: directed table, then random streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_PLAN      = 24;
  localparam int unsigned N_RANDOM    = 180;
  localparam int unsigned IDLE_PCT    = 16;
  localparam int unsigned DRAIN_CYC   = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [4:0] n_typed;
    logic [7:0] typed_byte;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_byte_t;

  typedef enum logic [1:0] {
    END_CLEAN,
    END_ON_FLAG,
    END_ON_PAIR_HEAD
  } stream_tail_t;

  logic clk = 1'b0;
  logic rst_n;

  lzwd_in_if  in_if();
  lzwd_out_if out_if();

  lzss_window_decoder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder image: window, write pointer, flag shifter and pair state.
  logic [7:0]    win_img [0:4095];
  logic [11:0]   wr_ptr;
  logic [15:0]   flag_bits;
  logic          pair_wait;
  logic [7:0]    pair_lo;
  decoded_byte_t step_bytes [$];
  decoded_byte_t pending_bytes [$];

  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        steady = 1'b0;
  stim_row_t   plan [0:N_PLAN-1];

  task automatic clear_img();
    for (int i = 0; i < 4096; i++) win_img[i] = lzwd_pkg::SPACE_BYTE;
    wr_ptr    = lzwd_pkg::WR_START;
    flag_bits = '0;
    pair_wait = 1'b0;
    pair_lo   = '0;
  endtask

  task automatic put_decoded(input logic [7:0] c);
    step_bytes.push_back('{data: c, last: 1'b0});
    win_img[wr_ptr] = c;
    wr_ptr = wr_ptr + 12'd1;
  endtask

  // Decodes one compressed byte into step_bytes and advances the image.
  task automatic lzss_decode_byte(input logic [7:0] b, input logic fin);
    logic [11:0] src;
    int          run;
    step_bytes.delete();
    if (pair_wait) begin
      src = {b[7:4], pair_lo};
      run = int'(b[3:0]) + int'(lzwd_pkg::MIN_MATCH_M1) + 1;
      // The read index follows the copy, so it may pick up bytes just written.
      for (int k = 0; k < run; k++) put_decoded(win_img[src + 12'(k)]);
      pair_wait = 1'b0;
      flag_bits = flag_bits >> 1;
    end else if (!flag_bits[8]) begin
      flag_bits = lzwd_pkg::FLAG_FILL | {8'h00, b};
    end else if (flag_bits[0]) begin
      put_decoded(b);
      flag_bits = flag_bits >> 1;
    end else begin
      pair_lo   = b;
      pair_wait = 1'b1;
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
    if (fin) clear_img();
  endtask

  function automatic stim_row_t free_row(input logic [7:0] b, input logic fin);
    return '{data: b, fin: fin, typed: 1'b0, n_typed: 5'd0, typed_byte: 8'h00};
  endfunction

  // Drives one request, waits for it to be taken and books its decoded bytes.
  task automatic send(input stim_row_t r);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= r.data;
    in_if.stream_end <= r.fin;
    do @(posedge clk); while (!in_if.ready);
    lzss_decode_byte(r.data, r.fin);
    if (r.typed) begin
      for (int i = 0; i < int'(r.n_typed); i++)
        pending_bytes.push_back('{data: r.typed_byte, last: i == int'(r.n_typed) - 1});
    end else begin
      foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
    end
    sent_cnt++;
  endtask

  function automatic logic [11:0] pick_source();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return wr_ptr - 12'($urandom_range(1, 24));
    if (sel < 80) return 12'($urandom);
    return 12'hff0 | 12'($urandom_range(0, 15));
  endfunction

  // A well-formed stream of random units; some streams stop short.
  task automatic run_stream(input int units, input stream_tail_t how);
    logic [7:0]  flags;
    logic [11:0] pos;
    logic [3:0]  len;
    logic        tail;
    for (int u = 0; u < units; u++) begin
      tail = (u == units - 1);
      if (u % 8 == 0) begin
        flags = 8'($urandom);
        send(free_row(flags, tail && how == END_ON_FLAG));
        if (tail && how == END_ON_FLAG) return;
      end
      if (flags[u % 8]) begin
        send(free_row(8'($urandom), tail));
      end else begin
        pos = pick_source();
        len = 4'($urandom);
        send(free_row(pos[7:0], tail && how == END_ON_PAIR_HEAD));
        if (!(tail && how == END_ON_PAIR_HEAD)) send(free_row({pos[11:8], len}, tail));
      end
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    decoded_byte_t exp_b;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output: out_byte=%h last_of_run=%b",
               out_if.out_byte, out_if.last_of_run);
        mismatch_cnt++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_if.out_byte !== exp_b.data) begin
          $error("out_byte: expected %h, actual %h", exp_b.data, out_if.out_byte);
          mismatch_cnt++;
        end
        if (out_if.last_of_run !== exp_b.last) begin
          $error("last_of_run: expected %b, actual %b", exp_b.last, out_if.last_of_run);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stream_tail_t how;
    int unsigned  r;
    int           units;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.stream_end = 1'b0;
    out_if.ready     = 1'b0;
    clear_img();

    // Fresh window is all spaces, so copies taken right after reset are typed in.
    plan = '{
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},                 // flag byte: eight pairs
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h0f, 1'b0, 1'b1, 5'd18, lzwd_pkg::SPACE_BYTE},  // longest copy from position 0
      '{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'hf0, 1'b0, 1'b1, 5'd3,  lzwd_pkg::SPACE_BYTE},  // shortest copy, read wraps
      '{8'h12, 1'b1, 1'b1, 5'd0,  8'h00},                 // stream ends on a pair head
      '{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},                 // flag byte: eight literals
      '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd1,  8'hff},
      '{8'ha5, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'h5a, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'h3c, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'hc3, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'h0f, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'hf0, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'h02, 1'b0, 1'b1, 5'd0,  8'h00},                 // pair, literal, then pairs
      '{8'hf4, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'hff, 1'b0, 1'b0, 5'd0,  8'h00},                 // overlapping copy, write wraps
      '{8'h81, 1'b0, 1'b1, 5'd1,  8'h81},
      '{8'h00, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'h00, 1'b1, 1'b0, 5'd0,  8'h00},                 // stream ends on a pair tail
      '{8'h01, 1'b1, 1'b1, 5'd0,  8'h00},                 // stream ends on a flag byte
      '{8'h01, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h7e, 1'b1, 1'b1, 5'd1,  8'h7e}                  // stream ends on a literal
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_PLAN; i++) send(plan[i]);

    while (sent_cnt < N_PLAN + N_RANDOM) begin
      steady = (sent_cnt >= N_PLAN + 90) && (sent_cnt < N_PLAN + 150);
      r = $urandom_range(0, 9);
      how = (r == 0) ? END_ON_FLAG : (r == 1) ? END_ON_PAIR_HEAD : END_CLEAN;
      units = (how == END_ON_FLAG) ? 8 * $urandom_range(0, 3) + 1 : $urandom_range(1, 30);
      run_stream(units, how);
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
